// ----- hw/rtl/rmdc_pkg.sv -----
// Shared types, constants and the CORDIC arctangent table for the direction classifier.
`default_nettype none
package rmdc_pkg;

  // CORDIC iteration count; the table covers at most 24 iterations
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned CordicRun   = (CordicSteps < 24) ? CordicSteps : 24;
  localparam int unsigned StepW       = (CordicRun > 1) ? $clog2(CordicRun) : 1;
  localparam int unsigned AtanIdxW    = 5;
  localparam int unsigned CordicW     = 48;   // holds 2^44 * 1.65 * sqrt(2) with sign
  localparam int unsigned FracSh      = 20;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam int unsigned PaddrW = 3;

  typedef enum logic [3:0] {
    DIR_NONE        = 4'd0,
    DIR_FWD         = 4'd1,
    DIR_FWD_LEFT    = 4'd2,
    DIR_LEFT        = 4'd3,
    DIR_BACK_LEFT   = 4'd4,
    DIR_BACK        = 4'd5,
    DIR_BACK_RIGHT  = 4'd6,
    DIR_RIGHT       = 4'd7,
    DIR_FWD_RIGHT   = 4'd8,
    DIR_TURN_LEFT   = 4'd9,
    DIR_TURN_RIGHT  = 4'd10
  } dir_e;

  // register index decode (word address bit 2)
  typedef enum logic {
    REG_STILL_LIMIT = 1'b0,
    REG_SPIN_LIMIT  = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SQUARE,
    F_DECIDE
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROTATE,
    B_FINISH
  } back_state_e;

  // one queued job: either a finished code or a step to run through CORDIC
  typedef struct packed {
    logic               is_move;
    dir_e               code;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic [15:0]        heading;
  } job_t;

  // atan(2^-i) as a 32-bit binary angle
  function automatic logic [31:0] atan_lut(input logic [AtanIdxW-1:0] idx);
    logic [31:0] v;
    v = 32'h0;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/rmdc_queue.sv -----
// Two-entry job queue between the classifier front end and the CORDIC back end.
`default_nettype none
module rmdc_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  rmdc_pkg::job_t      job_i,
  output logic                full_o,
  input  wire                 pop_i,
  output rmdc_pkg::job_t      job_o,
  output logic                empty_o
);

  rmdc_pkg::job_t                 mem_q [rmdc_pkg::QDepth];
  logic [rmdc_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [rmdc_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [rmdc_pkg::QCntW-1:0]     cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == rmdc_pkg::QCntW'(rmdc_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == rmdc_pkg::QPtrW'(rmdc_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == rmdc_pkg::QPtrW'(rmdc_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rmdc_front.sv -----
// Front end: takes samples, forms the step, does the idle test and the turn-in-place decision.
`default_nettype none
module rmdc_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire signed [23:0]   pos_x_i,
  input  wire signed [23:0]   pos_y_i,
  input  wire [15:0]          heading_i,
  input  wire [15:0]          still_limit_i,
  input  wire [14:0]          spin_limit_i,
  output logic                push_o,
  output rmdc_pkg::job_t      job_o,
  input  wire                 q_full_i
);

  rmdc_pkg::front_state_e state_q, state_d;

  logic               have_last_q, have_last_d;
  logic [23:0]        last_x_q, last_y_q;
  logic [15:0]        last_heading_q;

  logic               first_q;
  logic signed [24:0] dx_q, dy_q;
  logic [15:0]        dh_q;
  logic [15:0]        head_q;
  logic [49:0]        sqx_q, sqy_q;
  logic [31:0]        thr2_q;

  logic               accept;
  logic [24:0]        ux, uy;
  logic [50:0]        mag2;
  logic               is_idle;
  logic signed [16:0] dh_s, thr_s;
  rmdc_pkg::dir_e     turn_code;

  assign accept     = in_valid_i && (state_q == rmdc_pkg::F_IDLE);
  assign in_stall_o = (state_q != rmdc_pkg::F_IDLE);

  assign ux = dx_q[24] ? 25'(-dx_q) : 25'(dx_q);
  assign uy = dy_q[24] ? 25'(-dy_q) : 25'(dy_q);

  assign mag2    = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign is_idle = (mag2 < {19'b0, thr2_q});

  // heading change as signed 16 bit; a half turn reads as -32768
  assign dh_s = $signed({dh_q[15], dh_q});
  assign thr_s = $signed({2'b00, spin_limit_i});

  always_comb begin
    if (dh_s > thr_s) begin
      turn_code = rmdc_pkg::DIR_TURN_LEFT;
    end else if (dh_s < -thr_s) begin
      turn_code = rmdc_pkg::DIR_TURN_RIGHT;
    end else begin
      turn_code = rmdc_pkg::DIR_NONE;
    end
  end

  always_comb begin
    state_d     = state_q;
    have_last_d = have_last_q;
    push_o      = 1'b0;
    job_o.is_move = !first_q && !is_idle;
    job_o.code    = first_q ? rmdc_pkg::DIR_NONE : turn_code;
    job_o.dx      = dx_q;
    job_o.dy      = dy_q;
    job_o.heading = head_q;
    unique case (state_q)
      rmdc_pkg::F_IDLE: begin
        if (in_valid_i) begin
          have_last_d = 1'b1;
          state_d     = rmdc_pkg::F_SQUARE;
        end
      end
      rmdc_pkg::F_SQUARE: begin
        state_d = rmdc_pkg::F_DECIDE;
      end
      rmdc_pkg::F_DECIDE: begin
        if (!q_full_i) begin
          push_o  = 1'b1;
          state_d = rmdc_pkg::F_IDLE;
        end
      end
      default: state_d = rmdc_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= rmdc_pkg::F_IDLE;
      have_last_q    <= 1'b0;
      last_x_q       <= '0;
      last_y_q       <= '0;
      last_heading_q <= '0;
    end else begin
      state_q     <= state_d;
      have_last_q <= have_last_d;
      if (accept) begin
        last_x_q       <= pos_x_i;
        last_y_q       <= pos_y_i;
        last_heading_q <= heading_i;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      first_q <= !have_last_q;
      dx_q    <= $signed({pos_x_i[23], pos_x_i}) - $signed({last_x_q[23], last_x_q});
      dy_q    <= $signed({pos_y_i[23], pos_y_i}) - $signed({last_y_q[23], last_y_q});
      dh_q    <= heading_i - last_heading_q;
      head_q  <= heading_i;
    end
    if (state_q == rmdc_pkg::F_SQUARE) begin
      sqx_q  <= ux * ux;
      sqy_q  <= uy * uy;
      thr2_q <= still_limit_i * still_limit_i;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rmdc_back.sv -----
// Back end: serial CORDIC vectoring for moving steps, sector choice and the output register.
`default_nettype none
module rmdc_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  rmdc_pkg::job_t      job_i,
  input  wire                 q_empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic [3:0]          direction_o
);

  rmdc_pkg::back_state_e state_q, state_d;

  logic                                 out_valid_q, out_valid_d;
  rmdc_pkg::dir_e                       dir_q, dir_d;
  logic signed [rmdc_pkg::CordicW-1:0]  x_q, x_d, y_q, y_d;
  logic [31:0]                          z_q, z_d;
  logic [rmdc_pkg::StepW-1:0]           cnt_q, cnt_d;
  logic [15:0]                          head_q, head_d;
  logic                                 zero_q, zero_d;

  logic                                 can_load;
  logic signed [rmdc_pkg::CordicW-1:0]  ax, by, xs, ys;
  logic [31:0]                          atan_v;
  logic [31:0]                          z_rnd;
  logic [15:0]                          mv, rel, rel_off;
  rmdc_pkg::dir_e                       sector_code;

  assign can_load    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign direction_o = dir_q;

  // scale the step by 2^FracSh into the CORDIC word
  assign ax = {{(rmdc_pkg::CordicW - rmdc_pkg::FracSh - 25){job_i.dx[24]}}, job_i.dx,
               {rmdc_pkg::FracSh{1'b0}}};
  assign by = {{(rmdc_pkg::CordicW - rmdc_pkg::FracSh - 25){job_i.dy[24]}}, job_i.dy,
               {rmdc_pkg::FracSh{1'b0}}};

  assign xs     = x_q >>> cnt_q;
  assign ys     = y_q >>> cnt_q;
  assign atan_v = rmdc_pkg::atan_lut(rmdc_pkg::AtanIdxW'(cnt_q));

  // round the 32-bit angle to 16 bits; a zero step counts as angle 0
  assign z_rnd   = z_q + 32'h0000_8000;
  assign mv      = zero_q ? 16'h0 : z_rnd[31:16];
  assign rel     = mv - head_q;
  assign rel_off = rel + 16'h1000;
  assign sector_code = rmdc_pkg::dir_e'({1'b0, rel_off[15:13]} + 4'd1);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    dir_d       = dir_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    cnt_d       = cnt_q;
    head_d      = head_q;
    zero_d      = zero_q;
    pop_o       = 1'b0;
    unique case (state_q)
      rmdc_pkg::B_IDLE: begin
        if (!q_empty_i) begin
          if (!job_i.is_move) begin
            if (can_load) begin
              pop_o       = 1'b1;
              out_valid_d = 1'b1;
              dir_d       = job_i.code;
            end
          end else begin
            pop_o  = 1'b1;
            head_d = job_i.heading;
            zero_d = (job_i.dx == '0) && (job_i.dy == '0);
            cnt_d  = '0;
            // fold the left half plane over so the rotation starts within a quarter turn
            if (by[rmdc_pkg::CordicW-1]) begin
              x_d = -by;
              y_d = -ax;
              z_d = 32'h8000_0000;
            end else begin
              x_d = by;
              y_d = ax;
              z_d = 32'h0;
            end
            state_d = rmdc_pkg::B_ROTATE;
          end
        end
      end
      rmdc_pkg::B_ROTATE: begin
        if (!y_q[rmdc_pkg::CordicW-1] && (y_q != '0)) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + atan_v;
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - atan_v;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == rmdc_pkg::StepW'(rmdc_pkg::CordicRun - 1)) begin
          state_d = rmdc_pkg::B_FINISH;
        end
      end
      rmdc_pkg::B_FINISH: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          dir_d       = sector_code;
          state_d     = rmdc_pkg::B_IDLE;
        end
      end
      default: state_d = rmdc_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmdc_pkg::B_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    dir_q  <= dir_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    head_q <= head_d;
    zero_q <= zero_d;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/relative_move_direction_classifier.sv -----
// Top level of the relative movement direction classifier with its register port.
`default_nettype none
// Classifies each position/heading sample against the previous one and returns one
// direction code per transaction (0 none, 1..8 the eight 45-degree sectors relative to
// the heading, 9 turn-left, 10 turn-right). The very first sample after reset only
// primes the history and reports none. A step shorter than the still limit (compared as
// squared lengths) is judged as turning in place from the heading change; any other step
// has its bearing found by a serial CORDIC and is binned into a sector. The front end
// takes a sample through capture, square and decide and hands it to a two-deep job queue;
// the back end turns an idle or first sample straight into a result and a moving sample
// through load, 16 CORDIC iterations and sector select. The serial CORDIC loop therefore
// bounds the rate of moving transactions, though the front end keeps taking samples until
// the queue is full. The result sits in an output register, so the next sample can be
// taken while an earlier result is still stalled. Registers: still limit at byte address
// 0 (reset 16), spin limit at byte address 4 (reset 104); write only while idle.
module relative_move_direction_classifier (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // input transactions
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire signed [23:0]                   pos_x_i,
  input  wire signed [23:0]                   pos_y_i,
  input  wire [15:0]                          heading_i,
  // result transactions
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [3:0]                          direction_o,
  // register port
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire [rmdc_pkg::PaddrW-1:0]          paddr,
  input  wire [31:0]                          pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [15:0]        still_limit_q;
  logic [14:0]        spin_limit_q;
  logic               reg_wr;
  rmdc_pkg::reg_idx_e reg_sel;

  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_empty;
  rmdc_pkg::job_t     push_job;
  rmdc_pkg::job_t     head_job;

  // ---- register port: zero wait states, word decode on address bit 2 ----
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite;
  assign reg_sel = rmdc_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    unique case (reg_sel)
      rmdc_pkg::REG_STILL_LIMIT: prdata = {16'b0, still_limit_q};
      rmdc_pkg::REG_SPIN_LIMIT:  prdata = {17'b0, spin_limit_q};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      still_limit_q <= 16'd16;
      spin_limit_q  <= 15'd104;
    end else if (reg_wr) begin
      if (reg_sel == rmdc_pkg::REG_STILL_LIMIT) begin
        still_limit_q <= pwdata[15:0];
      end else begin
        spin_limit_q <= pwdata[14:0];
      end
    end
  end

  // ---- front end: history, step, idle test, turn decision ----
  rmdc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .heading_i     (heading_i),
    .still_limit_i (still_limit_q),
    .spin_limit_i  (spin_limit_q),
    .push_o        (push),
    .job_o         (push_job),
    .q_full_i      (q_full)
  );

  // ---- job queue: lets the front take the next sample during a CORDIC run ----
  rmdc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (q_empty)
  );

  // ---- back end: CORDIC bearing, sector, output register ----
  rmdc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .direction_o (direction_o)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/rmdc_checker.sv -----
// Port-level checker for the direction classifier and its bind to the top level.
`default_nettype none
module rmdc_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [3:0]  direction_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its code
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(direction_o))
    else $error("result changed while stalled");

  // only defined direction codes leave the block
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (direction_o <= rmdc_pkg::DIR_TURN_RIGHT))
    else $error("undefined direction code");

  // the front end is busy in the cycle after taking a sample
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("sample taken on consecutive cycles");

endmodule

bind relative_move_direction_classifier rmdc_checker u_rmdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .direction_o (direction_o)
);
`default_nettype wire
